### design/sha256_byte_stream_hasher_top_assert.svh
// Assertion macros for the SHA-256 byte-stream hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SHABS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHABS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/shabs_pkg.sv
// Types, constants and round functions of the SHA-256 byte-stream hasher.
package shabs_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam logic [31:0] INIT_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### design/sha256_byte_stream_hasher_top.sv
// SHA-256 hasher taking one message byte per beat, iterative one-round-per-cycle core.
// A plain byte is only buffered and counted; the byte that fills a 64-byte block starts 64 rounds
// of the shared round unit, then a fold of the working variables into the chain words.
// Finishing: pad bytes go in one per cycle (up to 72), then 1 or 2 block compressions,
// then 8 digest beats. Requests are stalled during padding, compression and digest output.
// Reset (synchronous, active high): chain words to the initial hash, counts cleared, idle.
module sha256_byte_stream_hasher_top
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel: one message byte per beat
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic        req_empty_message,
   // response channel: one digest word per beat
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   // sequencer
   state_type state_ff, state_in;

   // 512-bit block buffer; bytes shift in at the bottom, and during the rounds
   // it serves as the 16-word message schedule window (word 0 at the top)
   logic [511:0] buf_ff, buf_in;
   logic [5:0]   count_ff, count_in;      // bytes in the current block
   logic [60:0]  len_ff, len_in;          // message length in bytes, wraps

   logic [31:0]  chain_ff [8];
   logic [31:0]  chain_in [8];
   logic [31:0]  work_ff [8];             // a..h working variables
   logic [31:0]  work_in [8];
   logic [5:0]   round_ff, round_in;

   // finalization flags
   logic         pad_ff, pad_in;          // message is being finished
   logic         mark_ff, mark_in;        // 0x80 byte already pushed
   logic         lenph_ff, lenph_in;      // length bytes under way
   logic [2:0]   lidx_ff, lidx_in;        // next length byte
   logic         done_ff, done_in;        // last length byte pushed
   logic [2:0]   oidx_ff, oidx_in;        // digest word on the response port

   // decoded control
   logic         take_req, pad_step, do_round, do_fold, rsp_beat;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_empty_message) state_in = ST_PAD;
               else if (count_ff == LAST_SLOT) state_in = ST_ROUND;
               else if (req_is_last)           state_in = ST_PAD;
               else                            state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (count_ff == LAST_SLOT) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            priority if (done_ff) state_in = ST_EMIT;
            else if (pad_ff)      state_in = ST_PAD;
            else                  state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_stall && oidx_ff == LAST_WORD) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      take_req  = 1'b0;
      pad_step  = 1'b0;
      do_round  = 1'b0;
      do_fold   = 1'b0;
      rsp_beat  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            take_req  = req_valid;
         end
         ST_PAD:   pad_step = 1'b1;
         ST_ROUND: do_round = 1'b1;
         ST_FOLD:  do_fold  = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_beat  = !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign rsp_digest_word = chain_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == LAST_WORD);

   // ---------------------------------------------------------------- datapath
   logic        push;
   logic [7:0]  push_byte;
   logic [63:0] len_bits;
   logic        len_now;
   logic [31:0] wa, wb, wc, wd, we, wf, wg, wh;
   logic [31:0] w0, t1, t2, w_next;

   always_comb begin
      len_bits = {len_ff, 3'b000};
      len_now  = mark_ff && (lenph_ff || count_ff == LEN_OFFSET);

      // byte source: a message byte, or the next padding byte
      push      = 1'b0;
      push_byte = req_data_byte;
      if (take_req && !req_empty_message) begin
         push = 1'b1;
      end else if (pad_step) begin
         push = 1'b1;
         priority if (!mark_ff) push_byte = PAD_MARK;
         else if (len_now)      push_byte = len_bits[{~lidx_ff, 3'b000} +: 8];
         else                   push_byte = 8'h00;
      end

      // one SHA-256 round plus one schedule word
      wa = work_ff[0]; wb = work_ff[1]; wc = work_ff[2]; wd = work_ff[3];
      we = work_ff[4]; wf = work_ff[5]; wg = work_ff[6]; wh = work_ff[7];
      w0 = buf_ff[511:480];
      t1 = wh + big_sig1(we) + ((we & wf) ^ (~we & wg)) + ROUND_K[round_ff] + w0;
      t2 = big_sig0(wa) + ((wa & wb) ^ (wa & wc) ^ (wb & wc));
      w_next = small_sig1(buf_ff[63:32]) + buf_ff[223:192]
             + small_sig0(buf_ff[479:448]) + w0;

      buf_in   = buf_ff;
      count_in = count_ff;
      len_in   = len_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      lenph_in = lenph_ff;
      lidx_in  = lidx_ff;
      done_in  = done_ff;
      oidx_in  = oidx_ff;

      if (take_req && (req_empty_message || req_is_last)) pad_in = 1'b1;
      if (take_req && !req_empty_message) len_in = len_ff + 61'd1;

      if (pad_step) begin
         mark_in = 1'b1;
         if (mark_ff && len_now) begin
            lenph_in = 1'b1;
            lidx_in  = lidx_ff + 3'd1;
            if (lidx_ff == LAST_WORD) done_in = 1'b1;
         end
      end

      if (push) begin
         buf_in   = {buf_ff[503:0], push_byte};
         count_in = count_ff + 6'd1;
         if (count_ff == LAST_SLOT) begin
            work_in  = chain_ff;
            round_in = 6'd0;
         end
      end

      if (do_round) begin
         buf_in     = {buf_ff[479:0], w_next};
         round_in   = round_ff + 6'd1;
         work_in[7] = wg;
         work_in[6] = wf;
         work_in[5] = we;
         work_in[4] = wd + t1;
         work_in[3] = wc;
         work_in[2] = wb;
         work_in[1] = wa;
         work_in[0] = t1 + t2;
      end

      if (do_fold) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + work_ff[i];
      end

      if (rsp_beat) begin
         oidx_in = oidx_ff + 3'd1;
         if (oidx_ff == LAST_WORD) begin
            // back to a fresh message
            chain_in = INIT_HASH;
            len_in   = '0;
            count_in = '0;
            pad_in   = 1'b0;
            mark_in  = 1'b0;
            lenph_in = 1'b0;
            lidx_in  = '0;
            done_in  = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         len_ff   <= '0;
         round_ff <= '0;
         chain_ff <= INIT_HASH;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         lenph_ff <= 1'b0;
         lidx_ff  <= '0;
         done_ff  <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         lenph_ff <= lenph_in;
         lidx_ff  <= lidx_in;
         done_ff  <= done_in;
         oidx_ff  <= oidx_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      work_ff <= work_in;
   end

endmodule

### design/shabs_checker.sv
// Port-level checker for the SHA-256 byte-stream hasher, bound to the top level.
`include "sha256_byte_stream_hasher_top_assert.svh"

module shabs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_is_last,
   input logic        req_empty_message,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic req_take, rsp_take;
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // no new byte is taken while digest words are out
   `SHABS_ASSERT_NOW(a_busy_while_out, rsp_valid, req_stall, "byte taken during digest")

   // last_word flag marks word seven only
   `SHABS_ASSERT_NOW(a_last_flag, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last_word mismatch")

   // digest words come in order with no gap
   `SHABS_ASSERT_NEXT(a_word_order, rsp_take && !rsp_last_word, rsp_valid && (rsp_word_index == 3'($past(rsp_word_index) + 3'd1)), "digest word out of order")

   // a plain mid-message byte gives no digest
   `SHABS_ASSERT_NEXT(a_plain_byte, req_take && !req_is_last && !req_empty_message, !rsp_valid, "digest after a plain byte")

   // a stalled digest beat holds
   `SHABS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "stalled digest beat changed")

endmodule

bind sha256_byte_stream_hasher_top shabs_checker u_shabs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_is_last       (req_is_last),
   .req_empty_message (req_empty_message),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_digest_word   (rsp_digest_word),
   .rsp_word_index    (rsp_word_index),
   .rsp_last_word     (rsp_last_word)
);

### test/tb.sv
// Self-checking testbench for the SHA-256 byte-stream hasher: random messages, stalls, digest check.
module tb;

   // ---------------------------------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------------------------------
   localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
   localparam int DRAIN_CYCLES = 300;     // pad pass + two compressions + digest beats, with slack
   localparam int MAX_SHOWN    = 10;      // mismatches printed in full
   localparam int IDLE_PERCENT = 30;
   localparam int RANDOM_ITEMS = 170;     // total beats queued before the random part stops
   localparam int LONG_BEATS   = 67;      // most beats one near-boundary message can queue

   // SHA-256 framing
   localparam int          BLOCK_BYTES = 64;
   localparam int          LEN_SLOT    = 56;  // offset of the 64-bit bit length in the last block
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   localparam logic [31:0] SHA_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
      logic       empty_message;
   } msg_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   // ---------------------------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------------------------------
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte     = 8'h00;
   logic        req_is_last       = 1'b0;
   logic        req_empty_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_byte_stream_hasher_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_is_last       (req_is_last),
      .req_empty_message (req_empty_message),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word   (rsp_digest_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last_word     (rsp_last_word)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------------------------------------
   msg_beat_type    pending_beats [$];   // stimulus not yet offered to the DUT
   digest_beat_type digest_queue  [$];   // predicted digest words, oldest first
   int              queued_total   = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   logic            req_taken      = 1'b0;  // a request beat was accepted at the last rising edge

   // No idling on either side during this window, so back-to-back traffic is exercised too.
   wire quiet_stretch = (cycle_count >= 1500) && (cycle_count < 3500);

   // ---------------------------------------------------------------------------------------------
   // Hash predictor: own copy of chain words, block buffer and byte count
   // ---------------------------------------------------------------------------------------------
   logic [31:0] chain_h [0:7];
   logic [7:0]  blk_buf [0:63];
   int          blk_fill;
   logic [60:0] msg_bytes;   // byte count; bit length is this times eight, so wraps mod 2^64

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void clear_hash_state();
      int i;
      for (i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
      for (i = 0; i < BLOCK_BYTES; i++) blk_buf[i] = 8'h00;
      blk_fill  = 0;
      msg_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [0:63];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0   = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1   = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + SHA_K[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   function automatic void buffer_byte(input logic [7:0] b);
      blk_buf[blk_fill] = b;
      blk_fill++;
      if (blk_fill == BLOCK_BYTES) begin
         compress_block();
         blk_fill = 0;
      end
   endfunction

   // Pad, fold the bit length in, queue the eight digest words and start over.
   function automatic void close_message();
      logic [63:0]     bit_len;
      digest_beat_type word;
      int i;
      bit_len = {msg_bytes, 3'b000};
      buffer_byte(PAD_BYTE);
      while (blk_fill != LEN_SLOT) buffer_byte(8'h00);
      for (i = 0; i < 8; i++) buffer_byte(bit_len[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
         word.digest_word = chain_h[i];
         word.word_index  = 3'(i);
         word.last_word   = (i == 7);
         digest_queue.insert(digest_queue.size(), word);
      end
      clear_hash_state();
   endfunction

   // The empty flag overrides both the byte and is_last.
   function automatic void hash_beat(input msg_beat_type beat);
      if (beat.empty_message) begin
         close_message();
      end else begin
         buffer_byte(beat.data_byte);
         msg_bytes = msg_bytes + 61'd1;
         if (beat.is_last) close_message();
      end
   endfunction

   initial clear_hash_state();

   // ---------------------------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------------------------
   function automatic void queue_beat(input logic [7:0] data, input logic last,
                                      input logic empty);
      msg_beat_type beat;
      beat.data_byte     = data;
      beat.is_last       = last;
      beat.empty_message = empty;
      pending_beats.insert(pending_beats.size(), beat);
      queued_total++;
   endfunction

   // len random bytes; closed by is_last on the final byte, or by a trailing empty-flag beat
   function automatic void queue_message(input int len, input logic close_by_flag);
      int i;
      for (i = 0; i < len; i++)
         queue_beat(8'($urandom_range(0, 255)), (i == len - 1) && !close_by_flag, 1'b0);
      if (close_by_flag)
         queue_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endfunction

   function automatic void build_stimulus();
      int sel;
      // directed: empty messages, one-byte extremes, "abc", flag closing buffered bytes
      queue_beat(8'hff, 1'b1, 1'b1);   // empty flag with byte and is_last both set
      queue_beat(8'h00, 1'b0, 1'b1);   // empty flag on a fresh message
      queue_beat(8'h00, 1'b1, 1'b0);
      queue_beat(8'hff, 1'b1, 1'b0);
      queue_beat(8'h61, 1'b0, 1'b0);
      queue_beat(8'h62, 1'b0, 1'b0);
      queue_beat(8'h63, 1'b1, 1'b0);
      queue_beat(8'h80, 1'b0, 1'b0);   // bytes already buffered, then closed by the flag
      queue_beat(8'h7f, 1'b0, 1'b0);
      queue_beat(8'h55, 1'b0, 1'b1);
      queue_beat(8'haa, 1'b0, 1'b0);
      queue_beat(8'h00, 1'b1, 1'b1);
      // padding spills into a second block; then a message ending right on a block boundary
      queue_message(56, 1'b0);
      queue_message(64, 1'b0);
      // random part: mostly short well-formed messages, some near the block boundary
      while (queued_total < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 11);
         if (sel == 0 && queued_total + LONG_BEATS <= RANDOM_ITEMS)
            queue_message($urandom_range(52, 66), 1'($urandom_range(0, 1)));
         else if (sel <= 2)
            queue_message($urandom_range(0, 6), 1'b1);
         else
            queue_message($urandom_range(1, 8), 1'b0);
      end
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Request driver: changes on the falling edge, holds the beat while stalled
   // ---------------------------------------------------------------------------------------------
   always @(negedge clock) begin
      msg_beat_type beat;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_beats.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               beat = pending_beats.pop_front();
               req_valid         <= 1'b1;
               req_data_byte     <= beat.data_byte;
               req_is_last       <= beat.is_last;
               req_empty_message <= beat.empty_message;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure, also on the falling edge
   always @(negedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // ---------------------------------------------------------------------------------------------
   // Monitor: predicts on each accepted request beat, checks each accepted digest beat
   // ---------------------------------------------------------------------------------------------
   function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (mismatch_count < MAX_SHOWN)
         $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin
      digest_beat_type want;
      msg_beat_type    seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.data_byte     = req_data_byte;
            seen.is_last       = req_is_last;
            seen.empty_message = req_empty_message;
            hash_beat(seen);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               flag_mismatch("digest beat with none pending, word", 32'h0, rsp_digest_word);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_digest_word !== want.digest_word)
                  flag_mismatch("digest_word", want.digest_word, rsp_digest_word);
               if (rsp_word_index !== want.word_index)
                  flag_mismatch("word_index", 32'(want.word_index), 32'(rsp_word_index));
               if (rsp_last_word !== want.last_word)
                  flag_mismatch("last_word", 32'(want.last_word), 32'(rsp_last_word));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sha256_byte_stream_hasher_top regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Sequencing: reset, let the driver drain the stimulus, wait out the last digest
   // ---------------------------------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_beats.size() != 0 || req_valid || digest_queue.size() != 0)
         @(posedge clock);
      // any stray digest beat after this point is caught by the monitor
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0) begin
         $display("sha256_byte_stream_hasher_top regression: pass");
      end else begin
         $display("sha256_byte_stream_hasher_top regression: fail");
      end
      $finish;
   end

endmodule
